@@ design/ir_pulse_width_capture_macros.svh @@
// Assertion macros for the IR pulse width capture block.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef IR_PULSE_WIDTH_CAPTURE_MACROS_SVH
`define IR_PULSE_WIDTH_CAPTURE_MACROS_SVH

// Check on every rising edge, ignored while reset is high.
`define IRPWC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on every rising edge, reset included.
`define IRPWC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ design/irpwc_pkg.sv @@
// Types and fixed constants for the IR pulse width capture block.
// No dependencies; used by ir_pulse_width_capture.
package irpwc_pkg;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_WAIT = 2'd1,
      PH_CAPT = 2'd2,
      PH_DONE = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      REQ_ARM    = 2'd0,
      REQ_SAMPLE = 2'd1,
      REQ_TICK   = 2'd2,
      REQ_READ   = 2'd3
   } req_kind_type;

   localparam logic RSP_REPORT = 1'b0;
   localparam logic RSP_READ   = 1'b1;

   localparam logic LEVEL_MARK  = 1'b0;
   localparam logic LEVEL_SPACE = 1'b1;

   localparam int unsigned  EDGE_COUNT_W   = 7;
   localparam int unsigned  EDGE_TICKS_W   = 8;
   localparam int unsigned  RUN_W          = 16;
   localparam logic [15:0]  RUN_MAX        = 16'hFFFF;
   localparam logic [7:0]   CLIP_MAX       = 8'd255;
   localparam logic [15:0]  IDLE_END_RESET = 16'd250;
   localparam int unsigned  MIN_EDGES      = 2;

   typedef struct packed {
      logic                    kind;
      logic                    ok;
      logic [EDGE_COUNT_W-1:0] cnt;
      logic                    hit;
   } rsp_type;

endpackage

@@ design/ir_pulse_width_capture.sv @@
// IR pulse width capture: top level, run-length store in a synchronous memory.
// Depends on irpwc_pkg and ir_pulse_width_capture_macros.svh.
//
//   channel | dir | handshake               | payload
//   req     | in  | req_tvalid/req_tready   | tuser: req_type; tdata: level, timeout, index
//   rsp     | out | rsp_tvalid/rsp_tready   | tuser: result_kind; tdata: success, count, ticks
//   csr     | in  | csr_wr_en               | csr_wr_data: idle_limit
//
// One item per cycle while req_tready is high. A read result is registered in stage one
// together with the memory read, then in the output register. Reports follow the same path.
// Synchronous reset clears control state; the length store needs no clearing.
// req_tready drops only while both result stages are full and rsp_tready is low.
`include "ir_pulse_width_capture_macros.svh"

module ir_pulse_width_capture #(
   parameter int unsigned MAX_EDGES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,     // [1:0] req_type
   input  logic [23:0] req_tdata,     // [0] line_level, [16:1] arm_timeout, [22:17] read_index
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tuser,     // [0] result_kind
   output logic [15:0] rsp_tdata,     // [0] success, [7:1] run_count, [15:8] edge_ticks
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int unsigned AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int unsigned CW = $clog2(MAX_EDGES + 1);
   localparam int unsigned XW = CW + 6;

   logic                   req_xfer;
   logic                   in_level;
   logic [15:0]            in_timeout;
   logic [5:0]             in_index;
   irpwc_pkg::req_kind_type in_kind;

   logic [15:0]            idle_end_ff;
   irpwc_pkg::phase_type   phase_ff, phase_in;
   logic [CW-1:0]          stored_ff, stored_in;
   logic                   last_level_ff, last_level_in;
   logic [15:0]            run_ff, run_in;
   logic [15:0]            waited_ff, waited_in;
   logic [15:0]            limit_ff, limit_in;
   logic [CW-1:0]          reported_ff, reported_in;

   logic [7:0]             length_mem [MAX_EDGES];
   logic                   mem_we;
   logic [AW-1:0]          mem_wa;
   logic [7:0]             mem_wd;
   logic                   mem_re;
   logic [AW-1:0]          mem_ra;
   logic [7:0]             mem_rd_ff;

   logic                   s1_valid_ff, s1_valid_in;
   irpwc_pkg::rsp_type     s1_ff, s1_in;
   logic                   s2_load;
   logic                   rsp_valid_ff;
   logic                   rsp_kind_ff;
   logic                   rsp_ok_ff;
   logic [6:0]             rsp_cnt_ff;
   logic [7:0]             rsp_ticks_ff;

   logic [15:0]            run_inc;
   logic [7:0]             run_clip;
   logic [CW-1:0]          cnt_even;
   logic                   rpt_fire;
   logic [XW-1:0]          idx_wide;
   logic                   idx_hit;

   assign in_kind    = irpwc_pkg::req_kind_type'(req_tuser);
   assign in_level   = req_tdata[0];
   assign in_timeout = req_tdata[16:1];
   assign in_index   = req_tdata[22:17];

   assign req_tready = !(s1_valid_ff && rsp_valid_ff && !rsp_tready);
   assign req_xfer   = req_tvalid && req_tready;
   assign s2_load    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);

   assign run_inc  = (run_ff == irpwc_pkg::RUN_MAX) ? run_ff : 16'(run_ff + 16'd1);
   assign run_clip = (run_ff > 16'(irpwc_pkg::CLIP_MAX)) ? irpwc_pkg::CLIP_MAX : run_ff[7:0];
   assign cnt_even = {stored_ff[CW-1:1], 1'b0};
   assign idx_wide = XW'(in_index);
   assign idx_hit  = (idx_wide < XW'(reported_ff)) && (idx_wide < XW'(MAX_EDGES));
   assign mem_ra   = AW'(in_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_end_ff <= irpwc_pkg::IDLE_END_RESET;
      end else if (csr_wr_en) begin
         idle_end_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= irpwc_pkg::PH_IDLE;
         stored_ff     <= '0;
         last_level_ff <= 1'b0;
         run_ff        <= '0;
         waited_ff     <= '0;
         limit_ff      <= '0;
         reported_ff   <= '0;
      end else begin
         phase_ff      <= phase_in;
         stored_ff     <= stored_in;
         last_level_ff <= last_level_in;
         run_ff        <= run_in;
         waited_ff     <= waited_in;
         limit_ff      <= limit_in;
         reported_ff   <= reported_in;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      stored_in     = stored_ff;
      last_level_in = last_level_ff;
      run_in        = run_ff;
      waited_in     = waited_ff;
      limit_in      = limit_ff;
      reported_in   = reported_ff;
      mem_we        = 1'b0;
      mem_wa        = stored_ff[AW-1:0];
      mem_wd        = run_clip;
      mem_re        = 1'b0;
      rpt_fire      = 1'b0;
      s1_valid_in   = 1'b0;
      s1_in         = '0;
      if (req_xfer) begin
         unique case (in_kind)
            irpwc_pkg::REQ_ARM: begin
               phase_in    = irpwc_pkg::PH_WAIT;
               stored_in   = '0;
               waited_in   = '0;
               limit_in    = in_timeout;
               reported_in = '0;
            end
            irpwc_pkg::REQ_SAMPLE: begin
               if (phase_ff == irpwc_pkg::PH_WAIT) begin
                  if (in_level == irpwc_pkg::LEVEL_MARK) begin
                     phase_in      = irpwc_pkg::PH_CAPT;
                     last_level_in = irpwc_pkg::LEVEL_MARK;
                     run_in        = 16'd1;
                     stored_in     = '0;
                  end
               end else if (phase_ff == irpwc_pkg::PH_CAPT) begin
                  if (in_level != last_level_ff) begin
                     if (stored_ff < CW'(MAX_EDGES)) begin
                        mem_we    = 1'b1;
                        stored_in = CW'(stored_ff + 1'b1);
                     end else begin
                        phase_in = irpwc_pkg::PH_DONE;
                     end
                     last_level_in = in_level;
                     run_in        = 16'd1;
                  end else begin
                     run_in = run_inc;
                     if (in_level == irpwc_pkg::LEVEL_SPACE && run_inc > idle_end_ff) begin
                        phase_in = irpwc_pkg::PH_DONE;
                     end
                  end
               end
            end
            irpwc_pkg::REQ_TICK: begin
               priority if (phase_ff == irpwc_pkg::PH_IDLE) begin
               end else if (phase_ff == irpwc_pkg::PH_DONE) begin
                  rpt_fire    = 1'b1;
                  phase_in    = irpwc_pkg::PH_IDLE;
                  s1_valid_in = 1'b1;
                  s1_in.kind  = irpwc_pkg::RSP_REPORT;
                  if (stored_ff < CW'(irpwc_pkg::MIN_EDGES)) begin
                     reported_in = '0;
                  end else begin
                     reported_in = cnt_even;
                     s1_in.ok    = 1'b1;
                     s1_in.cnt   = irpwc_pkg::EDGE_COUNT_W'(cnt_even);
                  end
               end else if (waited_ff >= limit_ff) begin
                  rpt_fire    = 1'b1;
                  phase_in    = irpwc_pkg::PH_IDLE;
                  reported_in = '0;
                  s1_valid_in = 1'b1;
                  s1_in.kind  = irpwc_pkg::RSP_REPORT;
               end else begin
                  waited_in = 16'(waited_ff + 16'd1);
               end
            end
            irpwc_pkg::REQ_READ: begin
               mem_re      = idx_hit;
               s1_valid_in = 1'b1;
               s1_in.kind  = irpwc_pkg::RSP_READ;
               s1_in.hit   = idx_hit;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         length_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         mem_rd_ff <= length_mem[mem_ra];
      end
   end

   // hold a stalled result in stage one until the output register frees up
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         s1_valid_ff <= s1_valid_in;
      end else if (s2_load) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_ff <= s1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         rsp_kind_ff  <= s1_ff.kind;
         rsp_ok_ff    <= s1_ff.ok;
         rsp_cnt_ff   <= s1_ff.cnt;
         rsp_ticks_ff <= s1_ff.hit ? mem_rd_ff : 8'd0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {rsp_ticks_ff, rsp_cnt_ff, rsp_ok_ff};

   `IRPWC_ASSERT(a_count_bound, (stored_ff <= CW'(MAX_EDGES)), "stored count beyond store depth")
   `IRPWC_ASSERT(a_report_even, (!reported_ff[0]), "reported count is odd")
   `IRPWC_ASSERT(a_stall_blocks, (s1_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready), "input taken with both result stages blocked")
   `IRPWC_ASSERT(a_report_idle, (rpt_fire |=> phase_ff == irpwc_pkg::PH_IDLE), "phase not idle after a report")
   `IRPWC_ASSERT_ALWAYS(a_reset_clear, ($past(reset) |-> !s1_valid_ff && !rsp_valid_ff), "result stages not cleared by reset")

endmodule
